@@ rtl/core/adsrxf_pkg.sv @@
// Shared widths, register codes and handshake structs of the ADSR crossfade envelope unit.
package adsrxf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 24;
  localparam int GAIN_W    = 16;
  localparam int NUM_W     = TIME_W + GAIN_W;
  localparam int MUL_W     = TIME_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DATA_W    = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [GAIN_W-1:0] UNITY = {1'b1, {(GAIN_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOTE_LENGTH   = 3'd0,
    REG_ATTACK_LEN    = 3'd1,
    REG_DECAY_END     = 3'd2,
    REG_SUSTAIN_LEVEL = 3'd3,
    REG_RELEASE_LEN   = 3'd4,
    REG_FADE_IN_LEN   = 3'd5,
    REG_FADE_OUT_LEN  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [GAIN_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

endpackage

@@ rtl/core/adsrxf_divider.sv @@
// Restoring serial divider that yields one quotient bit per clock cycle.
module adsrxf_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  adsrxf_pkg::div_req_t req,
  output adsrxf_pkg::div_rsp_t rsp
);
  import adsrxf_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] rem_r;
  logic [GAIN_W-1:0] quo_r;
  logic [TIME_W-1:0] den_r;

  logic [TIME_W:0]   cand;
  logic [TIME_W:0]   diff;
  logic              fits;
  logic [TIME_W-1:0] rem_nxt;

  always_comb begin
    cand    = {rem_r, quo_r[GAIN_W-1]};
    diff    = cand - {1'b0, den_r};
    fits    = cand >= {1'b0, den_r};
    rem_nxt = fits ? diff[TIME_W-1:0] : cand[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(GAIN_W - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= req.num[NUM_W-1:GAIN_W];
        quo_r  <= req.num[GAIN_W-1:0];
        den_r  <= req.den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[GAIN_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GAIN_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ rtl/core/adsrxf_multiplier.sv @@
// Shared signed multiplier with a registered product.
module adsrxf_multiplier (
  input  logic                                   clk,
  input  adsrxf_pkg::mul_req_t                   req,
  output logic signed [adsrxf_pkg::PROD_W-1:0]   prod_r
);
  import adsrxf_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

endmodule

@@ rtl/core/adsr_crossfade_envelope_unit.sv @@
// Top level of the ADSR crossfade envelope unit: registers, sequencer and output stage.
//
// Each input transaction carries a stereo sample pair and a note-start flag; the unit forms a
// Q1.15 gain from the note time (attack, decay, sustain, release, times a crossfade factor
// outside attack), scales both samples by it and returns one result transaction whose tlast
// is set once the note time reaches the note length. The serial divider is used at most twice
// per transaction, and the single shared multiplier is used up to four times. The input is not
// ready while a transaction is being worked on. A finished result waits in the output register
// while the next transaction is accepted and worked on, but that transaction is not loaded into
// the output register until the waiting result has been taken.
module adsr_crossfade_envelope_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata fields from bit 0: left_sample, right_sample
  input  logic [adsrxf_pkg::DATA_W-1:0]      in_tdata,
  // in_tuser fields from bit 0: note_first
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata fields from bit 0: left_out, right_out
  output logic [adsrxf_pkg::DATA_W-1:0]      out_tdata,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [adsrxf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adsrxf_pkg::TIME_W-1:0]      cfg_wdata
);
  import adsrxf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_FADE, ST_FWAIT, ST_ENV, ST_EDIV, ST_EWAIT,
    ST_GMUL, ST_GAIN, ST_LMUL, ST_RMUL, ST_RES, ST_OUT
  } state_t;

  function automatic logic [SAMPLE_W-1:0] trunc_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p[PROD_W-1] ? p + PROD_W'(UNITY - 1'b1) : p;
    return adj[SAMPLE_W+GAIN_W-2:GAIN_W-1];
  endfunction

  state_t state_r;

  logic [TIME_W-1:0] note_length_r;
  logic [TIME_W-1:0] attack_len_r;
  logic [TIME_W-1:0] decay_end_r;
  logic [GAIN_W-1:0] sustain_level_r;
  logic [TIME_W-1:0] release_len_r;
  logic [TIME_W-1:0] fade_in_len_r;
  logic [TIME_W-1:0] fade_out_len_r;
  logic [TIME_W-1:0] note_time_r;

  logic [TIME_W-1:0]          t_r;
  logic signed [SAMPLE_W-1:0] left_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic fin_r, fout_r, past_r, att_r, dec_r, rel_r, last_r;
  logic [GAIN_W-1:0]   sus_r;
  logic [GAIN_W-1:0]   fade_r;
  logic [GAIN_W-1:0]   env_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [SAMPLE_W-1:0] left_res_r;
  logic [SAMPLE_W-1:0] right_res_r;

  logic [SAMPLE_W-1:0] out_left_r;
  logic [SAMPLE_W-1:0] out_right_r;
  logic                out_last_r;
  logic                out_valid_r;

  logic [TIME_W:0]     fo_sum;
  logic [TIME_W:0]     rl_sum;
  logic [TIME_W-1:0]   time_nxt;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] mul_p;

  adsrxf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  adsrxf_multiplier u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (mul_p)
  );

  always_comb begin
    fo_sum   = {1'b0, t_r} + {1'b0, fade_out_len_r};
    rl_sum   = {1'b0, t_r} + {1'b0, release_len_r};
    time_nxt = (t_r != '1) ? t_r + 1'b1 : t_r;
  end

  always_comb begin
    div_req = '0;
    case (state_r)
      ST_FADE: begin
        if (fin_r) begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(t_r) << (GAIN_W - 1);
          div_req.den   = fade_in_len_r;
        end else if (fout_r && !past_r) begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(note_length_r - t_r) << (GAIN_W - 1);
          div_req.den   = fade_out_len_r;
        end
      end
      ST_ENV: begin
        if (att_r) begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(t_r) << (GAIN_W - 1);
          div_req.den   = attack_len_r;
        end
      end
      ST_EDIV: begin
        div_req.start = 1'b1;
        div_req.num   = mul_p[NUM_W-1:0];
        div_req.den   = dec_r ? decay_end_r - attack_len_r : release_len_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_req = '0;
    case (state_r)
      ST_ENV: begin
        if (dec_r) begin
          mul_req.a = MUL_W'(t_r - attack_len_r);
          mul_req.b = MUL_W'(UNITY - sus_r);
        end else begin
          mul_req.a = MUL_W'(sus_r);
          mul_req.b = MUL_W'(note_length_r - t_r);
        end
      end
      ST_GMUL: begin
        mul_req.a = MUL_W'(fade_r);
        mul_req.b = MUL_W'(env_r);
      end
      ST_LMUL: begin
        mul_req.a = MUL_W'(left_r);
        mul_req.b = MUL_W'(gain_r);
      end
      ST_RMUL: begin
        mul_req.a = MUL_W'(right_r);
        mul_req.b = MUL_W'(gain_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_length_r   <= '0;
      attack_len_r    <= '0;
      decay_end_r     <= '0;
      sustain_level_r <= UNITY;
      release_len_r   <= '0;
      fade_in_len_r   <= '0;
      fade_out_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOTE_LENGTH:   note_length_r   <= cfg_wdata;
        REG_ATTACK_LEN:    attack_len_r    <= cfg_wdata;
        REG_DECAY_END:     decay_end_r     <= cfg_wdata;
        REG_SUSTAIN_LEVEL: sustain_level_r <= cfg_wdata[GAIN_W-1:0];
        REG_RELEASE_LEN:   release_len_r   <= cfg_wdata;
        REG_FADE_IN_LEN:   fade_in_len_r   <= cfg_wdata;
        REG_FADE_OUT_LEN:  fade_out_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      note_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            left_r  <= in_tdata[SAMPLE_W-1:0];
            right_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
            t_r     <= in_tuser ? '0 : note_time_r;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          fin_r       <= t_r < fade_in_len_r;
          fout_r      <= (fade_out_len_r != '0) && (fo_sum > {1'b0, note_length_r});
          past_r      <= t_r > note_length_r;
          att_r       <= t_r < attack_len_r;
          dec_r       <= t_r < decay_end_r;
          rel_r       <= (release_len_r != '0) && (rl_sum > {1'b0, note_length_r});
          sus_r       <= (sustain_level_r > UNITY) ? UNITY : sustain_level_r;
          note_time_r <= time_nxt;
          last_r      <= time_nxt >= note_length_r;
          state_r     <= ST_FADE;
        end
        ST_FADE: begin
          if (fin_r || (fout_r && !past_r)) begin
            state_r <= ST_FWAIT;
          end else begin
            fade_r  <= fout_r ? '0 : UNITY;
            state_r <= ST_ENV;
          end
        end
        ST_FWAIT: begin
          if (div_rsp.done) begin
            fade_r  <= div_rsp.quo;
            state_r <= ST_ENV;
          end
        end
        ST_ENV: begin
          if (att_r) begin
            state_r <= ST_EWAIT;
          end else if (dec_r || (rel_r && !past_r)) begin
            state_r <= ST_EDIV;
          end else begin
            env_r   <= rel_r ? '0 : sus_r;
            state_r <= ST_GMUL;
          end
        end
        ST_EDIV: begin
          state_r <= ST_EWAIT;
        end
        ST_EWAIT: begin
          if (div_rsp.done) begin
            if (att_r) begin
              gain_r  <= div_rsp.quo;
              state_r <= ST_LMUL;
            end else begin
              env_r   <= dec_r ? UNITY - div_rsp.quo : div_rsp.quo;
              state_r <= ST_GMUL;
            end
          end
        end
        ST_GMUL: begin
          state_r <= ST_GAIN;
        end
        ST_GAIN: begin
          gain_r  <= mul_p[2*GAIN_W-2:GAIN_W-1];
          state_r <= ST_LMUL;
        end
        ST_LMUL: begin
          state_r <= ST_RMUL;
        end
        ST_RMUL: begin
          left_res_r <= trunc_q15(mul_p);
          state_r    <= ST_RES;
        end
        ST_RES: begin
          right_res_r <= trunc_q15(mul_p);
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_left_r  <= left_res_r;
            out_right_r <= right_res_r;
            out_last_r  <= last_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = DATA_W'({out_right_r, out_left_r});

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in consecutive cycles");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_gain_unity: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LMUL |-> gain_r <= UNITY)
    else $error("envelope gain above unity");
`endif

endmodule
